FILE: src/assert_macros.svh
// Assertion macros shared by the RTL of the indexed insert/erase array.
// Depends on a clock named clk and an active-low reset named arst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property at every rising clock edge, off while reset is asserted.
`define ASSERT_CLK(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Check that an antecedent implies a consequent in the same cycle.
`define ASSERT_IMPLY(label, ante, cons, msg) \
	`ASSERT_CLK(label, (ante) |-> (cons), msg)

`endif

FILE: src/iiea_pkg.sv
// Package for the indexed insert/erase array: sizes, codes and payload types.
// No dependencies; used by every module of the block.
package iiea_pkg;

	localparam int CAPACITY   = 16;
	localparam int ELEM_WIDTH = 32;

	localparam int IDX_W  = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CNT_W  = $clog2(CAPACITY + 1);
	localparam int POS_W  = 5;
	localparam int DATA_W = 32;
	localparam int CMP_W  = (POS_W > CNT_W) ? POS_W : CNT_W;

	typedef logic [ELEM_WIDTH-1:0] elem_t;

	typedef enum logic [2:0] {
		OP_APPEND     = 3'd0,
		OP_INSERT     = 3'd1,
		OP_ERASE      = 3'd2,
		OP_READ_INDEX = 3'd3,
		OP_READ_FIRST = 3'd4,
		OP_READ_LAST  = 3'd5
	} opcode_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_RANGE = 2'd1,
		ST_FULL  = 2'd2,
		ST_EMPTY = 2'd3
	} status_t;

	typedef struct packed {
		opcode_t            opcode;
		logic [POS_W-1:0]   position;
		logic [DATA_W-1:0]  entry_value;
	} cmd_t;

	typedef struct packed {
		logic [DATA_W-1:0]  read_value;
		status_t            status;
		logic [4:0]         entry_count;
		logic               is_empty;
	} rsp_t;

	// Broadcast to every cell: insert opens a gap at pos, erase closes it.
	typedef enum logic [1:0] {
		SH_HOLD   = 2'd0,
		SH_INSERT = 2'd1,
		SH_ERASE  = 2'd2
	} shift_mode_t;

	typedef struct packed {
		shift_mode_t       mode;
		logic [IDX_W-1:0]  pos;
		elem_t             value;
	} shift_t;

endpackage

FILE: src/iiea_cell.sv
// One storage cell of the indexed insert/erase array chain.
// Depends on iiea_pkg; loads the new value or a neighbor's value per the broadcast.
module iiea_cell (
	input  logic                   clk,
	input  iiea_pkg::shift_t       shift,
	input  logic [iiea_pkg::IDX_W-1:0] cell_index,
	input  iiea_pkg::elem_t        left_data,
	input  iiea_pkg::elem_t        right_data,
	output iiea_pkg::elem_t        data_q
);
	import iiea_pkg::*;

	always_ff @(posedge clk) begin
		case (shift.mode)
			SH_INSERT: begin
				if (cell_index == shift.pos) begin
					data_q <= shift.value;
				end else if (cell_index > shift.pos) begin
					data_q <= left_data;
				end
			end
			SH_ERASE: begin
				if (cell_index >= shift.pos) begin
					data_q <= right_data;
				end
			end
			default: begin
				data_q <= data_q;
			end
		endcase
	end

endmodule

FILE: src/iiea_ctrl.sv
// Command decode for the indexed insert/erase array: checks, new count, read select.
// Depends on iiea_pkg; drives the cell broadcast and forms the response.
module iiea_ctrl (
	input  iiea_pkg::cmd_t             cmd,
	input  logic                       fire,
	input  logic [iiea_pkg::CNT_W-1:0] count,
	input  iiea_pkg::elem_t            cell_data [iiea_pkg::CAPACITY],
	output iiea_pkg::shift_t           shift,
	output logic [iiea_pkg::CNT_W-1:0] next_count,
	output iiea_pkg::rsp_t             rsp
);
	import iiea_pkg::*;

	logic [CMP_W-1:0] pos_ext;
	logic [CMP_W-1:0] cnt_ext;
	logic             is_full;
	logic             is_none;
	logic             rd_en;
	logic [IDX_W-1:0] rd_sel;
	status_t          status;
	shift_mode_t      mode;
	logic [IDX_W-1:0] sh_pos;

	assign pos_ext = CMP_W'(cmd.position);
	assign cnt_ext = CMP_W'(count);
	assign is_full = (count == CNT_W'(CAPACITY));
	assign is_none = (count == '0);

	always_comb begin
		status     = ST_OK;
		mode       = SH_HOLD;
		sh_pos     = cmd.position[IDX_W-1:0];
		next_count = count;
		rd_en      = 1'b0;
		rd_sel     = cmd.position[IDX_W-1:0];
		unique case (cmd.opcode)
			OP_APPEND: begin
				if (is_full) begin
					status = ST_FULL;
				end else begin
					mode       = SH_INSERT;
					sh_pos     = IDX_W'(count);
					next_count = count + CNT_W'(1);
				end
			end
			OP_INSERT: begin
				if (pos_ext > cnt_ext) begin
					status = ST_RANGE;
				end else if (is_full) begin
					status = ST_FULL;
				end else begin
					mode       = SH_INSERT;
					next_count = count + CNT_W'(1);
				end
			end
			OP_ERASE: begin
				if (pos_ext >= cnt_ext) begin
					status = ST_RANGE;
				end else begin
					mode       = SH_ERASE;
					next_count = count - CNT_W'(1);
				end
			end
			OP_READ_INDEX: begin
				if (pos_ext >= cnt_ext) begin
					status = ST_RANGE;
				end else begin
					rd_en = 1'b1;
				end
			end
			OP_READ_FIRST: begin
				rd_sel = '0;
				if (is_none) begin
					status = ST_EMPTY;
				end else begin
					rd_en = 1'b1;
				end
			end
			OP_READ_LAST: begin
				rd_sel = IDX_W'(count - CNT_W'(1));
				if (is_none) begin
					status = ST_EMPTY;
				end else begin
					rd_en = 1'b1;
				end
			end
			default: begin
				status = ST_OK;
			end
		endcase
	end

	// Cells move only on an accepted transaction.
	assign shift.mode  = fire ? mode : SH_HOLD;
	assign shift.pos   = sh_pos;
	assign shift.value = elem_t'(cmd.entry_value);

	assign rsp.read_value  = rd_en ? DATA_W'(cell_data[rd_sel]) : '0;
	assign rsp.status      = status;
	assign rsp.entry_count = 5'(next_count);
	assign rsp.is_empty    = (next_count == '0);

endmodule

FILE: src/indexed_insert_erase_array.sv
// Top level of the indexed insert/erase array: cell chain, count and response register.
// Depends on iiea_pkg, iiea_ctrl, iiea_cell and assert_macros.svh.
//
//   channel | direction | handshake              | payload
//   cmd     | in        | cmd_valid / cmd_ready  | iiea_pkg::cmd_t (opcode, position, value)
//   rsp     | out       | rsp_valid / rsp_ready  | iiea_pkg::rsp_t (value, status, count, empty)
//
// Decode, the shift of the whole cell row and the response are all done at the
// accepting edge, so one transaction per cycle is sustained while rsp_ready is high.
// The response register holds one result; a new command is taken while that result
// is taken in the same cycle, and cmd_ready drops only while a result waits unread.
// Reset clears the entry count and the response valid; cell contents stay undefined
// until written and are never read below the count before being written.
`include "assert_macros.svh"

module indexed_insert_erase_array (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            cmd_valid,
	output logic            cmd_ready,
	input  iiea_pkg::cmd_t  cmd,
	output logic            rsp_valid,
	input  logic            rsp_ready,
	output iiea_pkg::rsp_t  rsp
);
	import iiea_pkg::*;

	logic [CNT_W-1:0] count_q;
	logic [CNT_W-1:0] next_count;
	logic             rsp_valid_q;
	rsp_t             rsp_q;
	rsp_t             rsp_next;
	shift_t           shift;
	logic             fire;
	elem_t            cell_data [CAPACITY];

	// Take a command whenever the response slot is empty or being drained.
	assign cmd_ready = !rsp_valid_q || rsp_ready;
	assign fire      = cmd_valid && cmd_ready;

	iiea_ctrl u_ctrl (
		.cmd        (cmd),
		.fire       (fire),
		.count      (count_q),
		.cell_data  (cell_data),
		.shift      (shift),
		.next_count (next_count),
		.rsp        (rsp_next)
	);

	// Row of cells: on insert each cell above pos takes its left neighbor, on erase each from pos up its right.
	for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
		elem_t left_d;
		elem_t right_d;

		if (g == 0) begin : g_first
			assign left_d = '0;
		end else begin : g_left
			assign left_d = cell_data[g-1];
		end

		if (g == CAPACITY - 1) begin : g_last
			assign right_d = '0;
		end else begin : g_right
			assign right_d = cell_data[g+1];
		end

		iiea_cell u_cell (
			.clk        (clk),
			.shift      (shift),
			.cell_index (IDX_W'(g)),
			.left_data  (left_d),
			.right_data (right_d),
			.data_q     (cell_data[g])
		);
	end

	// Advance the count on every accepted transaction; failed commands leave it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (fire) begin
			count_q <= next_count;
		end
	end

	// Hold the response until taken; load a fresh one on each transaction.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (fire) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			rsp_q <= rsp_next;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	`ASSERT_CLK(a_count_bound, count_q <= CNT_W'(CAPACITY), "entry count past capacity")
	`ASSERT_IMPLY(a_rsp_count, rsp_valid_q, 5'(count_q) == rsp_q.entry_count,
		"pending response count differs from held count")
	`ASSERT_IMPLY(a_full_status, rsp_valid_q && rsp_q.status == ST_FULL,
		count_q == CNT_W'(CAPACITY), "full status while not full")
	`ASSERT_IMPLY(a_value_ok, rsp_valid_q && rsp_q.read_value != '0,
		rsp_q.status == ST_OK, "read value returned on a failed command")

endmodule
